[sv/prescaled_match_timer_macros.svh]
// ----------------------------------------------------------------------------
// prescaled_match_timer_macros.svh
// assertion macros shared by the timer's checker
// ----------------------------------------------------------------------------
`ifndef PRESCALED_MATCH_TIMER_MACROS_SVH
`define PRESCALED_MATCH_TIMER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer property violated");

// consequent checked in the cycle after the antecedent
`define PMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer property violated");

`endif

[sv/pmt_pkg.sv]
// ----------------------------------------------------------------------------
// pmt_pkg
// types and constants shared by the prescaled match timer
// ----------------------------------------------------------------------------
package pmt_pkg;

    localparam int NUM_CH     = 4;
    localparam int CH_W       = 2;
    localparam int REG_W      = 32;
    localparam int TICK_W     = 32;
    localparam int DATA_W     = 4;
    localparam int ACT_W      = 3;
    localparam int ACTIONS_W  = NUM_CH * ACT_W;
    localparam int SUM_W      = TICK_W + 1;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = 6;
    localparam int IDX_W      = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    // action bits within one channel's group
    localparam int ACT_IRQ  = 0;
    localparam int ACT_SUB  = 1;
    localparam int ACT_STOP = 2;

    // control word bits
    localparam int CTL_EN  = 0;
    localparam int CTL_RST = 1;

    typedef enum logic [IDX_W-1:0] {
        REG_MATCH0,
        REG_MATCH1,
        REG_MATCH2,
        REG_MATCH3,
        REG_ACTIONS,
        REG_PRESCALE
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_ADVANCE,
        OP_CONTROL,
        OP_CLEAR,
        OP_READ
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ADD,
        ST_MATCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic            load;
        logic            div_step;
        logic            add;
        logic            match;
        logic [CH_W-1:0] ch;
        logic            emit;
    } pmt_cmd_t;

    typedef struct packed {
        logic enabled;
        logic out_free;
    } pmt_status_t;

endpackage

[sv/pmt_ctrl.sv]
// ----------------------------------------------------------------------------
// pmt_ctrl
// sequencer: accept, then divide, add and channel checks for an advance while enabled, then emit
// ----------------------------------------------------------------------------
module pmt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pmt_pkg::opcode_t     opcode,
    input  pmt_pkg::pmt_status_t status,
    output pmt_pkg::pmt_cmd_t    cmd
);

    pmt_pkg::state_t              state_reg, state_next;
    logic [pmt_pkg::STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmt_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pmt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (opcode == pmt_pkg::OP_ADVANCE && status.enabled)
                    begin
                        state_next = pmt_pkg::ST_DIVIDE;
                        step_next  = '0;
                    end
                    else
                    begin
                        state_next = pmt_pkg::ST_EMIT;
                    end
                end
            end
            pmt_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == pmt_pkg::STEP_W'(pmt_pkg::DIV_STEPS - 1))
                begin
                    state_next = pmt_pkg::ST_ADD;
                end
                else
                begin
                    step_next = step_reg + pmt_pkg::STEP_W'(1);
                end
            end
            pmt_pkg::ST_ADD:
            begin
                cmd.add    = 1'b1;
                step_next  = '0;
                state_next = pmt_pkg::ST_MATCH;
            end
            pmt_pkg::ST_MATCH:
            begin
                cmd.match = 1'b1;
                cmd.ch    = step_reg[pmt_pkg::CH_W-1:0];
                if (step_reg == pmt_pkg::STEP_W'(pmt_pkg::NUM_CH - 1))
                begin
                    state_next = pmt_pkg::ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + pmt_pkg::STEP_W'(1);
                end
            end
            pmt_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = pmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pmt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/pmt_datapath.sv]
// ----------------------------------------------------------------------------
// pmt_datapath
// timer state, config registers, radix-2 divider, match unit, output word
// ----------------------------------------------------------------------------
module pmt_datapath
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pmt_pkg::pmt_cmd_t               cmd,
    output pmt_pkg::pmt_status_t            status,
    input  pmt_pkg::opcode_t                opcode,
    input  logic [pmt_pkg::TICK_W-1:0]      elapsed_ticks,
    input  logic [pmt_pkg::DATA_W-1:0]      write_data,
    input  logic                            wr_en,
    input  logic [pmt_pkg::IDX_W-1:0]       wr_index,
    input  logic [pmt_pkg::REG_W-1:0]       wr_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pmt_pkg::REG_W-1:0]       count_value,
    output logic [pmt_pkg::NUM_CH-1:0]      interrupt_flags,
    output logic                            running,
    output logic                            irq
);

    // configuration
    logic [pmt_pkg::REG_W-1:0]     match_value_reg [pmt_pkg::NUM_CH];
    logic [pmt_pkg::ACTIONS_W-1:0] actions_reg;
    logic [pmt_pkg::REG_W-1:0]     prescale_limit_reg;

    // timer state
    logic [COUNT_WIDTH-1:0]        count_reg, count_next;
    logic [pmt_pkg::REG_W-1:0]     prescale_reg, prescale_next;
    logic                          enable_reg, enable_next;
    logic [pmt_pkg::NUM_CH-1:0]    flags_reg, flags_next;

    // divider and match working registers
    logic [pmt_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [pmt_pkg::SUM_W-1:0]     rem_reg, rem_next;
    logic [pmt_pkg::SUM_W-1:0]     divisor_reg, divisor_next;
    logic [COUNT_WIDTH-1:0]        before_reg, before_next;

    // output word
    logic                          out_valid_reg, out_valid_next;
    logic [pmt_pkg::REG_W-1:0]     out_count_reg;
    logic [pmt_pkg::NUM_CH-1:0]    out_flags_reg;
    logic                          out_running_reg;
    logic                          out_irq_reg;

    logic [pmt_pkg::SUM_W:0]       rem_shift;
    logic [pmt_pkg::SUM_W:0]       rem_diff;
    logic [pmt_pkg::REG_W-1:0]     mv;
    logic [pmt_pkg::ACT_W-1:0]     act;
    logic [pmt_pkg::REG_W-1:0]     count_ext;
    logic [pmt_pkg::REG_W-1:0]     before_ext;
    logic                          hit;

    assign status.enabled  = enable_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pmt_pkg::NUM_CH; i++)
            begin
                match_value_reg[i] <= '0;
            end
            actions_reg        <= '0;
            prescale_limit_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                pmt_pkg::REG_MATCH0:   match_value_reg[0] <= wr_data;
                pmt_pkg::REG_MATCH1:   match_value_reg[1] <= wr_data;
                pmt_pkg::REG_MATCH2:   match_value_reg[2] <= wr_data;
                pmt_pkg::REG_MATCH3:   match_value_reg[3] <= wr_data;
                pmt_pkg::REG_ACTIONS:  actions_reg <= wr_data[pmt_pkg::ACTIONS_W-1:0];
                pmt_pkg::REG_PRESCALE: prescale_limit_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prescale_reg  <= '0;
            enable_reg    <= 1'b0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            prescale_reg  <= prescale_next;
            enable_reg    <= enable_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        before_reg  <= before_next;
        if (cmd.emit)
        begin
            out_count_reg   <= pmt_pkg::REG_W'(count_reg);
            out_flags_reg   <= flags_reg;
            out_running_reg <= enable_reg;
            out_irq_reg     <= |flags_reg;
        end
    end

    // one quotient bit per step
    assign rem_shift = {rem_reg, quo_reg[pmt_pkg::SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    assign mv         = match_value_reg[cmd.ch];
    assign act        = actions_reg[cmd.ch*pmt_pkg::ACT_W +: pmt_pkg::ACT_W];
    assign count_ext  = pmt_pkg::REG_W'(count_reg);
    assign before_ext = pmt_pkg::REG_W'(before_reg);
    assign hit        = (before_ext < mv) && (count_ext >= mv);

    always_comb
    begin
        count_next     = count_reg;
        prescale_next  = prescale_reg;
        enable_next    = enable_reg;
        flags_next     = flags_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        before_next    = before_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            case (opcode)
                pmt_pkg::OP_CONTROL:
                begin
                    if (write_data[pmt_pkg::CTL_RST])
                    begin
                        count_next    = '0;
                        prescale_next = '0;
                    end
                    enable_next = write_data[pmt_pkg::CTL_EN];
                end
                pmt_pkg::OP_CLEAR:
                begin
                    flags_next = flags_reg & ~write_data;
                end
                default: ;
            endcase
            quo_next     = {1'b0, prescale_reg} + {1'b0, elapsed_ticks};
            rem_next     = '0;
            divisor_next = {1'b0, prescale_limit_reg} + pmt_pkg::SUM_W'(1);
            before_next  = count_reg;
        end

        if (cmd.div_step)
        begin
            if (!rem_diff[pmt_pkg::SUM_W])
            begin
                rem_next = rem_diff[pmt_pkg::SUM_W-1:0];
                quo_next = {quo_reg[pmt_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[pmt_pkg::SUM_W-1:0];
                quo_next = {quo_reg[pmt_pkg::SUM_W-2:0], 1'b0};
            end
        end

        if (cmd.add)
        begin
            count_next    = count_reg + quo_reg[COUNT_WIDTH-1:0];
            prescale_next = rem_reg[pmt_pkg::REG_W-1:0];
        end

        if (cmd.match && hit)
        begin
            if (act[pmt_pkg::ACT_IRQ])
            begin
                flags_next[cmd.ch] = 1'b1;
            end
            if (act[pmt_pkg::ACT_STOP])
            begin
                enable_next = 1'b0;
            end
            if (act[pmt_pkg::ACT_SUB])
            begin
                count_next = count_reg - mv[COUNT_WIDTH-1:0];
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign count_value     = out_count_reg;
    assign interrupt_flags = out_flags_reg;
    assign running         = out_running_reg;
    assign irq             = out_irq_reg;

endmodule

[sv/prescaled_match_timer.sv]
// ----------------------------------------------------------------------------
// prescaled_match_timer
// timer with prescaler and four match channels, one status word per command
// ----------------------------------------------------------------------------
// an advance while enabled runs, after acceptance, 33 divider steps, an add step,
//   four channel checks and an emit step, which sets the registered m_tvalid
// other commands and advances while stopped go from acceptance straight to emit
// a new command is taken only in idle, once the last one has emitted; the radix-2
//   divider sets the pace of advances; a stalled output holds emit
// reset: rst_n clears count, prescale count, enable, flags, output valid and config registers
// ----------------------------------------------------------------------------
module prescaled_match_timer
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // command words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pmt_pkg::S_TDATA_W-1:0]     s_tdata,   // elapsed_ticks, write_data, pad
    input  logic [1:0]                        s_tuser,   // opcode
    // status words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pmt_pkg::M_TDATA_W-1:0]     m_tdata,   // count_value, interrupt_flags,
                                                         // running, irq, pad
    // register writes
    input  logic                              wr_en,
    input  logic [pmt_pkg::IDX_W-1:0]         wr_index,
    input  logic [pmt_pkg::REG_W-1:0]         wr_data
);

    localparam int OUT_USED_W = pmt_pkg::REG_W + pmt_pkg::NUM_CH + 2;

    pmt_pkg::pmt_cmd_t                cmd;
    pmt_pkg::pmt_status_t             status;
    pmt_pkg::opcode_t                 opcode;
    logic [pmt_pkg::TICK_W-1:0]       elapsed_ticks;
    logic [pmt_pkg::DATA_W-1:0]       write_data;
    logic [pmt_pkg::REG_W-1:0]        count_value;
    logic [pmt_pkg::NUM_CH-1:0]       interrupt_flags;
    logic                             running;
    logic                             irq;

    // unpack the command word
    assign opcode        = pmt_pkg::opcode_t'(s_tuser);
    assign elapsed_ticks = s_tdata[pmt_pkg::TICK_W-1:0];
    assign write_data    = s_tdata[pmt_pkg::TICK_W +: pmt_pkg::DATA_W];

    // sequencer: accepts only when idle, holds in emit until the output frees
    pmt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd)
    );

    // timer state, divider and match unit; the output register lets the
    // next command in while a status word still waits
    pmt_datapath
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .opcode          (opcode),
        .elapsed_ticks   (elapsed_ticks),
        .write_data      (write_data),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .count_value     (count_value),
        .interrupt_flags (interrupt_flags),
        .running         (running),
        .irq             (irq)
    );

    // pack the status word, count in the low bits
    assign m_tdata = {{(pmt_pkg::M_TDATA_W - OUT_USED_W){1'b0}},
                      irq, running, interrupt_flags, count_value};

endmodule

[sv/pmt_checker.sv]
// ----------------------------------------------------------------------------
// pmt_checker
// port-level checks for the prescaled match timer
// ----------------------------------------------------------------------------
`include "prescaled_match_timer_macros.svh"

module pmt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    logic [1:0] pend_reg, pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // commands taken but not yet answered
    always_comb
    begin
        case ({in_acc, out_acc})
            2'b10:   pend_next = pend_reg + 2'd1;
            2'b01:   pend_next = pend_reg - 2'd1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `PMT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PMT_ASSERT_NOW(a_irq_flags, clk, rst_n, m_tvalid, m_tdata[37] == (|m_tdata[35:32]))
    `PMT_ASSERT_NOW(a_no_orphan, clk, rst_n, m_tvalid, pend_reg != 2'd0)
    `PMT_ASSERT_NOW(a_pend_bound, clk, rst_n, 1'b1, pend_reg != 2'd3)

endmodule

bind prescaled_match_timer pmt_checker u_pmt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
